// File: sv/bgrc_pkg.sv
// Shared types, command codes and sizing constants for the bit grid region checker.
// No dependencies; the other design files but bgrc_rsp_if refer to this package by scoped names.
package bgrc_pkg;

    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;

    localparam int COORD_W    = 8;   // signed coordinate fields
    localparam int IDX_W      = 7;   // non-negative coordinate after clamping
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int Q_DEPTH    = 2;   // ops held between front and back

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_CELL  = 2'd1;
    localparam logic [1:0] CMD_RECT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    // Classified command as handed from front to back.
    // For single-cell commands x0/y0 carry the cell column/row.
    typedef struct packed {
        logic [1:0]       cmd;
        logic             bit_value;
        logic             in_grid;
        logic             empty;
        logic [IDX_W-1:0] x0;
        logic [IDX_W-1:0] x1;
        logic [IDX_W-1:0] y0;
        logic [IDX_W-1:0] y1;
    } t_op;

    typedef struct packed {
        logic cell_bit;
        logic region_clear;
        logic out_of_range;
    } t_result;

endpackage

// File: sv/bgrc_req_if.sv
// Request channel (valid/ready plus command payload) of the bit grid region checker.
// Depends on bgrc_pkg for the coordinate width.
interface bgrc_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          cmd;
    logic signed [bgrc_pkg::COORD_W-1:0] col;
    logic signed [bgrc_pkg::COORD_W-1:0] row;
    logic signed [bgrc_pkg::COORD_W-1:0] col_last;
    logic signed [bgrc_pkg::COORD_W-1:0] row_last;
    logic                                bit_value;

    modport source (output valid, cmd, col, row, col_last, row_last, bit_value, input ready);
    modport sink   (input valid, cmd, col, row, col_last, row_last, bit_value, output ready);
endinterface

// File: sv/bgrc_rsp_if.sv
// Response channel (valid/ready plus result payload) of the bit grid region checker.
// No dependencies.
interface bgrc_rsp_if;
    logic valid;
    logic ready;
    logic cell_bit;
    logic region_clear;
    logic out_of_range;

    modport source (output valid, cell_bit, region_clear, out_of_range, input ready);
    modport sink   (input valid, cell_bit, region_clear, out_of_range, output ready);
endinterface

// File: sv/bgrc_front.sv
// Front end: grid size registers, request acceptance and command classification.
// Depends on bgrc_pkg and bgrc_req_if; feeds bgrc_queue.
module bgrc_front #(
    parameter int GRID_COLS = bgrc_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = bgrc_pkg::GRID_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bgrc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bgrc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    bgrc_req_if.sink                          i_req,
    input  logic                              i_block,
    input  logic                              i_q_ready,
    output logic                              o_push,
    output bgrc_pkg::t_op                     o_op
);

    logic [bgrc_pkg::IDX_W-1:0] r_grid_width;
    logic [bgrc_pkg::IDX_W-1:0] r_grid_height;
    logic [bgrc_pkg::IDX_W-1:0] w_eff;
    logic [bgrc_pkg::IDX_W-1:0] h_eff;
    logic [bgrc_pkg::IDX_W-1:0] x0, x1, y0, y1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 7'd1;
            r_grid_height <= 7'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bgrc_pkg::CFG_GRID_WIDTH) begin
                r_grid_width <= i_cfg_data;
            end
            if (i_cfg_idx == bgrc_pkg::CFG_GRID_HEIGHT) begin
                r_grid_height <= i_cfg_data;
            end
        end
    end

    // Zero acts as one, anything above the built size acts as the built size.
    always_comb begin
        if (r_grid_width == '0) begin
            w_eff = 7'd1;
        end else if (32'(r_grid_width) > GRID_COLS) begin
            w_eff = 7'(GRID_COLS);
        end else begin
            w_eff = r_grid_width;
        end
        if (r_grid_height == '0) begin
            h_eff = 7'd1;
        end else if (32'(r_grid_height) > GRID_ROWS) begin
            h_eff = 7'(GRID_ROWS);
        end else begin
            h_eff = r_grid_height;
        end
    end

    always_comb begin
        x0 = i_req.col[7] ? '0 : i_req.col[6:0];
        y0 = i_req.row[7] ? '0 : i_req.row[6:0];
        x1 = (i_req.col_last[6:0] > w_eff - 7'd1) ? w_eff - 7'd1 : i_req.col_last[6:0];
        y1 = (i_req.row_last[6:0] > h_eff - 7'd1) ? h_eff - 7'd1 : i_req.row_last[6:0];

        o_op.cmd       = i_req.cmd;
        o_op.bit_value = i_req.bit_value;
        o_op.in_grid   = !i_req.col[7] && !i_req.row[7] &&
                         (i_req.col[6:0] < w_eff) && (i_req.row[6:0] < h_eff);
        // a negative last coordinate lies before any clamped first one
        o_op.empty     = i_req.col_last[7] || i_req.row_last[7] || (x0 > x1) || (y0 > y1);
        o_op.x0        = x0;
        o_op.x1        = x1;
        o_op.y0        = y0;
        o_op.y1        = y1;
    end

    assign i_req.ready = i_q_ready && !i_block;
    assign o_push      = i_req.valid && i_req.ready;

endmodule

// File: sv/bgrc_queue.sv
// Small FIFO of classified ops between the front end and the back end.
// Depends on bgrc_pkg for the op type and depth.
module bgrc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bgrc_pkg::t_op i_push_op,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output bgrc_pkg::t_op o_op
);

    localparam int PW = (bgrc_pkg::Q_DEPTH > 1) ? $clog2(bgrc_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(bgrc_pkg::Q_DEPTH + 1);

    bgrc_pkg::t_op r_slot [bgrc_pkg::Q_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(bgrc_pkg::Q_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_ready = (r_count != CW'(bgrc_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= f_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= f_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// File: sv/bgrc_back.sv
// Back end: grid memory, clearing sweep, op sequencer and result register.
// Depends on bgrc_pkg and bgrc_rsp_if; takes ops from bgrc_queue.
module bgrc_back #(
    parameter int GRID_COLS = bgrc_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = bgrc_pkg::GRID_ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  bgrc_pkg::t_op i_q_op,
    output logic          o_pop,
    output logic          o_clearing,
    bgrc_rsp_if.source    o_rsp
);

    localparam int RAW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CAW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CELL  = 3'd2;
    localparam logic [2:0] S_RECT  = 3'd3;
    localparam logic [2:0] S_HOLD  = 3'd4;

    logic [GRID_COLS-1:0] mem [GRID_ROWS];
    logic [GRID_COLS-1:0] r_rd_data;

    logic [2:0]                 r_state, n_state;
    logic [RAW-1:0]             r_clr, n_clr;
    bgrc_pkg::t_op              r_op;
    logic [bgrc_pkg::IDX_W-1:0] r_y, n_y;
    logic                       r_more, n_more;
    logic                       r_ok, n_ok;
    bgrc_pkg::t_result          r_res, n_res;
    logic                       r_ovalid;
    bgrc_pkg::t_result          r_ores;

    logic                 rd_en, wr_en, wr_bit;
    logic [RAW-1:0]       rd_addr, wr_addr;
    logic [GRID_COLS-1:0] wr_mask, span;
    logic                 fin, can_emit, o_load, row_ok;
    bgrc_pkg::t_result    fin_res, o_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int b = 0; b < GRID_COLS; b++) begin
                if (wr_mask[b]) begin
                    mem[wr_addr][b] <= wr_bit;
                end
            end
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        for (int b = 0; b < GRID_COLS; b++) begin
            span[b] = (7'(b) >= r_op.x0) && (7'(b) <= r_op.x1);
        end
    end

    assign row_ok   = ((r_rd_data & span) == span);
    assign can_emit = !r_ovalid || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_y     = r_y;
        n_more  = r_more;
        n_ok    = r_ok;
        n_res   = r_res;
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = RAW'(r_y);
        wr_en   = 1'b0;
        wr_addr = RAW'(i_q_op.y0);
        wr_mask = '0;
        wr_bit  = i_q_op.bit_value;
        fin     = 1'b0;
        fin_res = '0;

        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_mask = '1;
                wr_bit  = 1'b0;
                n_clr   = r_clr + RAW'(1);
                if (r_clr == RAW'(GRID_ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    case (i_q_op.cmd)
                        bgrc_pkg::CMD_WRITE: begin
                            fin                  = 1'b1;
                            fin_res.out_of_range = !i_q_op.in_grid;
                            if (i_q_op.in_grid) begin
                                wr_en                      = 1'b1;
                                wr_mask[CAW'(i_q_op.x0)]   = 1'b1;
                            end
                        end
                        bgrc_pkg::CMD_CELL: begin
                            if (i_q_op.in_grid) begin
                                rd_en   = 1'b1;
                                rd_addr = RAW'(i_q_op.y0);
                                n_state = S_CELL;
                            end else begin
                                fin                  = 1'b1;
                                fin_res.out_of_range = 1'b1;
                            end
                        end
                        bgrc_pkg::CMD_RECT: begin
                            if (i_q_op.empty) begin
                                fin                  = 1'b1;
                                fin_res.region_clear = 1'b1;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = RAW'(i_q_op.y0);
                                n_y     = i_q_op.y0 + 7'd1;
                                n_more  = (i_q_op.y0 != i_q_op.y1);
                                n_ok    = 1'b1;
                                n_state = S_RECT;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_CELL: begin
                fin                  = 1'b1;
                fin_res.cell_bit     = r_rd_data[CAW'(r_op.x0)];
                fin_res.region_clear = r_rd_data[CAW'(r_op.x0)];
            end
            S_RECT: begin
                // one row issued per cycle, the row read last cycle is checked now
                n_ok = r_ok && row_ok;
                if (r_more) begin
                    rd_en  = 1'b1;
                    n_y    = r_y + 7'd1;
                    n_more = (r_y != r_op.y1);
                end else begin
                    fin                  = 1'b1;
                    fin_res.region_clear = r_ok && row_ok;
                end
            end
            S_HOLD: begin
                if (can_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (can_emit) begin
                n_state = S_IDLE;
            end else begin
                n_res   = fin_res;
                n_state = S_HOLD;
            end
        end
    end

    assign o_load = can_emit && (fin || (r_state == S_HOLD));
    assign o_data = fin ? fin_res : r_res;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_q_op;
        end
        if (o_load) begin
            r_ores <= o_data;
        end
        r_y   <= n_y;
        r_ok  <= n_ok;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_more   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_more  <= n_more;
            if (o_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_clearing         = (r_state == S_CLEAR);
    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.cell_bit     = r_ores.cell_bit;
    assign o_rsp.region_clear = r_ores.region_clear;
    assign o_rsp.out_of_range = r_ores.out_of_range;

endmodule

// File: sv/bit_grid_region_checker.sv
// Bit grid region checker: a GRID_ROWS x GRID_COLS grid of one-bit cells with cell writes,
// cell reads and rectangle checks. After reset the grid memory is swept to zero, one row per
// cycle, so the request channel stays not-ready until the sweep ends. Requests are classified
// in the front end and wait in a two-entry queue for the back end, which owns the grid memory
// (one read, one write port). Writes, empty rectangles and out-of-grid cells finish as the op
// leaves the queue; a cell read waits for its row, a rectangle check reads the clamped rows
// one per cycle. Each result then sits in an output register until taken. Grid size registers
// (index 0 width, 1 height) must be written only while idle; the block does not enforce it.
// Depends on bgrc_pkg, bgrc_req_if, bgrc_rsp_if, bgrc_front, bgrc_queue and bgrc_back.
module bit_grid_region_checker #(
    parameter int GRID_COLS = bgrc_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = bgrc_pkg::GRID_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bgrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bgrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bgrc_req_if.sink                        i_req,
    bgrc_rsp_if.source                      o_rsp
);

    logic          q_push, q_ready, q_pop, q_valid, clearing;
    bgrc_pkg::t_op push_op, pop_op;

    bgrc_front #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_block    (clearing),
        .i_q_ready  (q_ready),
        .o_push     (q_push),
        .o_op       (push_op)
    );

    bgrc_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_push_op (push_op),
        .o_ready   (q_ready),
        .i_pop     (q_pop),
        .o_valid   (q_valid),
        .o_op      (pop_op)
    );

    bgrc_back #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_op     (pop_op),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_rsp      (o_rsp)
    );

    // clearing sweep always starts right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> clearing)
        else $error("grid clearing did not start after reset");

    // nothing may reach the queue before the grid is cleared
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !q_push && !q_pop)
        else $error("transaction moved during grid clearing");

    // a result may not come up while the grid was still being cleared
    a_rsp_from_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> !$past(clearing))
        else $error("result produced during grid clearing");

endmodule

// File: sim/grid_tb_pkg.sv
// Request type and expected-result tracker for the bit grid region checker testbench.
// Depends on bgrc_pkg for command codes, register indexes, field widths and t_result.
package grid_tb_pkg;
    import bgrc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int N_COLS = GRID_COLS_DEF;
    localparam int N_ROWS = GRID_ROWS_DEF;

    typedef struct {
        logic [1:0]                cmd;
        logic signed [COORD_W-1:0] col;
        logic signed [COORD_W-1:0] row;
        logic signed [COORD_W-1:0] col_last;
        logic signed [COORD_W-1:0] row_last;
        logic                      bit_value;
    } grid_req_t;

    // Mirrors the grid and the size registers; queues one answer per accepted request.
    class grid_tracker;
        logic [N_COLS-1:0]     cells [N_ROWS];
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        t_result               answers [$];
        int                    fails;

        function new();
            foreach (cells[i]) cells[i] = '0;
            width_reg  = 1;
            height_reg = 1;
            fails      = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_GRID_WIDTH) width_reg = val;
            else if (idx == CFG_GRID_HEIGHT) height_reg = val;
        endfunction

        // zero acts as one, oversize acts as the physical size
        function int clamp_dim(int v, int lim);
            if (v == 0) return 1;
            if (v > lim) return lim;
            return v;
        endfunction

        function int cols_in_use();
            return clamp_dim(int'(width_reg), N_COLS);
        endfunction

        function int rows_in_use();
            return clamp_dim(int'(height_reg), N_ROWS);
        endfunction

        function t_result predict_answer(grid_req_t q);
            int                c, r, cl, rl, w, h, x0, x1, y0, y1;
            bit                in_grid;
            logic [N_COLS-1:0] span;
            t_result           a;
            c  = q.col;
            r  = q.row;
            cl = q.col_last;
            rl = q.row_last;
            w  = cols_in_use();
            h  = rows_in_use();
            a  = '0;
            in_grid = (c >= 0) && (r >= 0) && (c < w) && (r < h);
            case (q.cmd)
                CMD_WRITE: begin
                    a.out_of_range = !in_grid;
                    if (in_grid) cells[r][c] = q.bit_value;
                end
                CMD_CELL: begin
                    a.out_of_range = !in_grid;
                    if (in_grid) a.cell_bit = cells[r][c];
                    a.region_clear = a.cell_bit;
                end
                CMD_RECT: begin
                    x0 = (c < 0) ? 0 : c;
                    y0 = (r < 0) ? 0 : r;
                    x1 = (cl > w - 1) ? w - 1 : cl;
                    y1 = (rl > h - 1) ? h - 1 : rl;
                    a.region_clear = 1'b1;
                    if (x0 <= x1 && y0 <= y1) begin
                        span = '0;
                        for (int i = x0; i <= x1; i++) span[i] = 1'b1;
                        for (int y = y0; y <= y1; y++) begin
                            if ((cells[y] & span) != span) a.region_clear = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
            return a;
        endfunction

        function void note_request(grid_req_t q);
            answers.push_back(predict_answer(q));
        endfunction

        function int pending();
            return answers.size();
        endfunction

        task report(string msg);
            fails++;
            if (fails <= 40) $display("mismatch: %s", msg);
        endtask

        task check_answer(t_result got);
            t_result want;
            if (answers.size() == 0) begin
                report("result transaction with no request outstanding");
                return;
            end
            want = answers.pop_front();
            if (got.cell_bit !== want.cell_bit)
                report($sformatf("cell_bit got %0b expected %0b", got.cell_bit, want.cell_bit));
            if (got.region_clear !== want.region_clear)
                report($sformatf("region_clear got %0b expected %0b",
                                 got.region_clear, want.region_clear));
            if (got.out_of_range !== want.out_of_range)
                report($sformatf("out_of_range got %0b expected %0b",
                                 got.out_of_range, want.out_of_range));
        endtask
    endclass

endpackage

// File: sim/tb_top.sv
// Top-level testbench for bit_grid_region_checker: directed and random commands over several
// grid sizes, random stalls on both channels, results checked against grid_tracker.
// Depends on bgrc_pkg, bgrc_req_if, bgrc_rsp_if, grid_tb_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bgrc_pkg::*;
    import grid_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 160;
    localparam int N_PHASES       = 10;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  no_idle = 1'b0;
    int                    hold_reqs = 0;
    int                    quiet_cycles = 0;
    int                    items_issued = 0;

    grid_tracker tracker = new();

    bgrc_req_if req_if();
    bgrc_rsp_if rsp_if();

    always #1 i_clk = ~i_clk;

    bit_grid_region_checker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    function automatic grid_req_t make_req(logic [1:0] cmd, int c, int r, int cl, int rl,
                                           logic bv);
        grid_req_t q;
        q.cmd       = cmd;
        q.col       = COORD_W'(c);
        q.row       = COORD_W'(r);
        q.col_last  = COORD_W'(cl);
        q.row_last  = COORD_W'(rl);
        q.bit_value = bv;
        return q;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 255)) - 128;
    endfunction

    // mostly inside the grid, now and then just past an edge
    function automatic int near_coord(int n);
        if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? -1 : n;
        return $urandom_range(0, n - 1);
    endfunction

    function automatic grid_req_t random_req(int w, int h);
        grid_req_t q;
        int        pick, c, r;
        pick = $urandom_range(0, 99);
        c    = near_coord(w);
        r    = near_coord(h);
        q    = make_req(CMD_WRITE, c, r, any_coord(), any_coord(), $urandom_range(0, 3) != 0);
        if (pick < 40) begin
        end else if (pick < 45) begin
            q = make_req(CMD_WRITE, any_coord(), any_coord(), any_coord(), any_coord(),
                         1'($urandom_range(0, 1)));
        end else if (pick < 65) begin
            q.cmd = CMD_CELL;
        end else if (pick < 70) begin
            q = make_req(CMD_CELL, any_coord(), any_coord(), any_coord(), any_coord(),
                         1'($urandom_range(0, 1)));
        end else if (pick < 93) begin
            q = make_req(CMD_RECT, c, r, c + $urandom_range(0, 3), r + $urandom_range(0, 3),
                         1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0) q.col_last = COORD_W'(c - 1);
        end else if (pick < 98) begin
            q = make_req(CMD_RECT, any_coord(), any_coord(), any_coord(), any_coord(),
                         1'($urandom_range(0, 1)));
        end else begin
            q = make_req(CMD_UNUSED, any_coord(), any_coord(), any_coord(), any_coord(),
                         1'($urandom_range(0, 1)));
        end
        return q;
    endfunction

    // valid stays high from one transaction to the next unless a gap is taken
    task automatic issue(grid_req_t q);
        if (!no_idle && $urandom_range(0, 99) < 9) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.cmd       <= q.cmd;
        req_if.col       <= q.col;
        req_if.row       <= q.row;
        req_if.col_last  <= q.col_last;
        req_if.row_last  <= q.row_last;
        req_if.bit_value <= q.bit_value;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        tracker.note_request(q);
        items_issued++;
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_grid(int w, int h);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_GRID_WIDTH;
        cfg_data <= CFG_DATA_W'(w);
        @(posedge i_clk);
        tracker.set_register(CFG_GRID_WIDTH, CFG_DATA_W'(w));
        cfg_idx  <= CFG_GRID_HEIGHT;
        cfg_data <= CFG_DATA_W'(h);
        @(posedge i_clk);
        tracker.set_register(CFG_GRID_HEIGHT, CFG_DATA_W'(h));
        cfg_we   <= 1'b0;
    endtask

    // set a small block of cells, check it, knock one cell out, check again
    task automatic fill_and_check(int w, int h);
        int x0, x1, y0, y1;
        x0 = $urandom_range(0, w - 1);
        x1 = x0 + $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0) begin
            x0 = 0;
            x1 = w - 1;
        end
        if (x1 > w - 1) x1 = w - 1;
        y0 = $urandom_range(0, h - 1);
        y1 = y0 + $urandom_range(0, 1);
        if (y1 > h - 1) y1 = h - 1;
        for (int y = y0; y <= y1; y++)
            for (int x = x0; x <= x1; x++) issue(make_req(CMD_WRITE, x, y, 0, 0, 1'b1));
        issue(make_req(CMD_RECT, x0, y0, x1, y1, 1'b0));
        issue(make_req(CMD_WRITE, $urandom_range(x0, x1), $urandom_range(y0, y1), 0, 0, 1'b0));
        issue(make_req(CMD_RECT, x0, y0, x1, y1, 1'b0));
    endtask

    // result side: check each transaction, stall at random or on request
    initial begin
        int      hold_left;
        int      hold_seen;
        t_result got;
        hold_left = 0;
        hold_seen = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                got.cell_bit     = rsp_if.cell_bit;
                got.region_clear = rsp_if.region_clear;
                got.out_of_range = rsp_if.out_of_range;
                tracker.check_answer(got);
            end
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= i_rst_n && !(!no_idle && $urandom_range(0, 99) < 9);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) === 1'b1 || (rsp_if.valid && rsp_if.ready) === 1'b1)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        int  phase_w [N_PHASES];
        int  phase_h [N_PHASES];
        int  phase_start;
        bit  held;
        bit  paused;
        phase_w = '{64, 1, 0, 127, 8, 3, 64, 65, 0, 0};
        phase_h = '{64, 1, 0, 127, 5, 64, 2, 70, 0, 0};
        phase_w[8] = $urandom_range(0, 127);
        phase_h[8] = $urandom_range(0, 127);
        phase_w[9] = $urandom_range(0, 127);
        phase_h[9] = $urandom_range(0, 127);
        held   = 1'b0;
        paused = 1'b0;

        cfg_we           <= 1'b0;
        cfg_idx          <= '0;
        cfg_data         <= '0;
        req_if.valid     <= 1'b0;
        req_if.cmd       <= '0;
        req_if.col       <= '0;
        req_if.row       <= '0;
        req_if.col_last  <= '0;
        req_if.row_last  <= '0;
        req_if.bit_value <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on the full 64 x 64 grid, starting empty
        set_grid(64, 64);
        issue(make_req(CMD_CELL, 0, 0, 0, 0, 1'b0));
        issue(make_req(CMD_RECT, -128, -128, 127, 127, 1'b0));
        issue(make_req(CMD_RECT, 5, 5, 4, 4, 1'b0));          // inverted rectangle
        issue(make_req(CMD_RECT, 70, 0, 100, 3, 1'b0));       // starts right of the grid
        issue(make_req(CMD_WRITE, 0, 0, 0, 0, 1'b1));
        issue(make_req(CMD_WRITE, 63, 63, 0, 0, 1'b1));
        issue(make_req(CMD_WRITE, 63, 0, 0, 0, 1'b1));
        issue(make_req(CMD_WRITE, 0, 63, 0, 0, 1'b1));
        issue(make_req(CMD_CELL, 63, 63, 0, 0, 1'b0));
        issue(make_req(CMD_WRITE, 64, 0, 0, 0, 1'b1));
        issue(make_req(CMD_WRITE, -1, 5, 0, 0, 1'b1));
        issue(make_req(CMD_WRITE, 5, -128, 0, 0, 1'b1));
        issue(make_req(CMD_WRITE, 127, 127, 127, 127, 1'b1));
        issue(make_req(CMD_CELL, -1, 0, 0, 0, 1'b0));
        issue(make_req(CMD_CELL, 0, 64, 0, 0, 1'b0));
        issue(make_req(CMD_CELL, 127, -128, 0, 0, 1'b1));
        issue(make_req(CMD_RECT, 0, 0, 0, 0, 1'b0));
        issue(make_req(CMD_RECT, -5, -5, 0, 0, 1'b0));        // start clamped up to zero
        issue(make_req(CMD_RECT, 63, 63, 127, 127, 1'b0));    // end clamped to the corner
        issue(make_req(CMD_RECT, 0, 0, 63, 0, 1'b0));
        issue(make_req(CMD_WRITE, 0, 0, 0, 0, 1'b0));
        issue(make_req(CMD_CELL, 0, 0, 0, 0, 1'b0));
        issue(make_req(CMD_UNUSED, -1, -1, -1, -1, 1'b1));
        issue(make_req(CMD_UNUSED, 0, 0, 0, 0, 1'b0));
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            set_grid(phase_w[p], phase_h[p]);
            no_idle <= (p == 2);
            phase_start = items_issued;
            while (items_issued < phase_start + PHASE_ITEMS) begin
                if (p == 1 && !held && items_issued >= phase_start + 40) begin
                    held = 1'b1;
                    hold_reqs <= hold_reqs + 1;
                end
                if (p == 4 && !paused && items_issued >= phase_start + 80) begin
                    paused = 1'b1;
                    drain();
                end
                if ($urandom_range(0, 99) < 4)
                    fill_and_check(tracker.cols_in_use(), tracker.rows_in_use());
                else
                    issue(random_req(tracker.cols_in_use(), tracker.rows_in_use()));
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (tracker.fails == 0 && tracker.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
